[rtl/rsa_pkg.sv]
// ----------------------------------------------------------------------------
// rsa_pkg
// Constants, types and helpers shared by the ring scratch allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int RingBytes = 4096;
  localparam int RingWords = RingBytes / 4;
  localparam int OffW      = $clog2(RingBytes + 1);
  localparam int WordAw    = $clog2(RingWords);
  localparam int WalkW     = $clog2(RingWords + 2);

  localparam logic [31:0] FreeMark = 32'h8000_0000;
  localparam logic [31:0] SizeMask = 32'h7fff_ffff;
  localparam logic [31:0] PadWord  = 32'hffff_ffff;
  localparam logic [31:0] BaseMask = 32'hffff_ff00;
  localparam logic [20:0] UsableMax = 21'h1f_ffff;

  localparam logic [1:0] OpAlloc = 2'd0;
  localparam logic [1:0] OpFree  = 2'd1;
  localparam logic [1:0] OpQuery = 2'd2;
  localparam logic [1:0] OpSpare = 2'd3;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StBacking = 2'd1;
  localparam logic [1:0] StNull    = 2'd2;
  localparam logic [1:0] StDouble  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACHECK,
    S_AHDR,
    S_APAD,
    S_FRD,
    S_FCHK,
    S_HDR,
    S_FADV,
    S_FCHK2,
    S_OUT
  } state_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic              wen;
    logic [WordAw-1:0] addr;
    logic [31:0]       wdata;
  } mem_req_t;

  function automatic logic [8:0] eff_align(input logic [8:0] a);
    logic [8:0] r;
    r = 9'd4;
    for (int b = 2; b <= 8; b++) begin
      if (a[b]) r = 9'(1 << b);
    end
    return r;
  endfunction

endpackage

[rtl/rsa_ram.sv]
// ----------------------------------------------------------------------------
// rsa_ram
// Ring word store: one port, registered read data.
// ----------------------------------------------------------------------------
module rsa_ram (
  input  logic               clk,
  input  rsa_pkg::mem_req_t  req,
  output logic [31:0]        rdata
);
  import rsa_pkg::*;

  logic [31:0] mem [RingWords];

  always_ff @(posedge clk) begin
    if (req.wen) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

[rtl/ring_scratch_allocator.sv]
// ----------------------------------------------------------------------------
// ring_scratch_allocator
// Ring-buffer scratch allocator: allocate, free and size query over a ring
// of word storage, one request at a time under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  signals                                        dir
//  cfg      cfg_valid cfg_ready cfg_data                   in
//  request  in_valid in_ready op request_size alignment    in
//           data_address
//  result   out_valid out_ready status result_address      out
//           usable_bytes
//
// One request at a time. Allocate computes offsets, writes the header,
// then writes the pad words; free and query walk back word by word to the
// header; a free then advances the free pointer past freed blocks. All of it
// goes through the single port of the ring word memory. The result sits in
// an output register until taken; the next request is accepted after that.
// Synchronous reset clears pointers and base; ring words are not cleared.
// ----------------------------------------------------------------------------
module ring_scratch_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [19:0] request_size,
  input  logic [8:0]  alignment,
  input  logic [31:0] data_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] result_address,
  output logic [20:0] usable_bytes
);
  import rsa_pkg::*;

  state_t state, state_next;

  logic [31:0]     base;
  logic [OffW-1:0] alloc_offset, alloc_offset_next;
  logic [OffW-1:0] free_offset, free_offset_next;

  // request registers
  logic [1:0]      rop;
  logic [20:0]     rsize;
  logic [8:0]      ralign;
  logic [31:0]     roff;
  logic [OffW-1:0] hh, hh_next;      // header byte offset
  logic [21:0]     dd, dd_next;      // data byte offset
  logic [22:0]     pp, pp_next;      // end byte offset
  logic            wrapped, wrapped_next;
  logic [WordAw:0] w, w_next;        // walk word index
  logic [WalkW-1:0] nstep, nstep_next;
  logic [31:0]     hdr, hdr_next;

  logic [1:0]  status_next;
  logic [31:0] result_next;
  logic [20:0] usable_next;

  mem_req_t    req;
  logic [31:0] rdata;

  rsa_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  logic            in_use;
  logic [22:0]     pcand;
  logic [31:0]     gap;
  logic [31:0]     len;
  logic [31:0]     step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      base         <= '0;
      alloc_offset <= '0;
      free_offset  <= '0;
    end else begin
      state        <= state_next;
      alloc_offset <= alloc_offset_next;
      free_offset  <= free_offset_next;
      if (cfg_valid && cfg_ready) begin
        base <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rop    <= op;
      rsize  <= (21'(request_size) + 21'd3) & ~21'd3;
      ralign <= eff_align(alignment);
      roff   <= data_address - (base & BaseMask);
    end
    hh             <= hh_next;
    dd             <= dd_next;
    pp             <= pp_next;
    wrapped        <= wrapped_next;
    w              <= w_next;
    nstep          <= nstep_next;
    hdr            <= hdr_next;
    status         <= status_next;
    result_address <= result_next;
    usable_bytes   <= usable_next;
  end

  always_comb begin
    state_next        = state;
    alloc_offset_next = alloc_offset;
    free_offset_next  = free_offset;
    hh_next      = hh;
    dd_next      = dd;
    pp_next      = pp;
    wrapped_next = wrapped;
    w_next       = w;
    nstep_next   = nstep;
    hdr_next     = hdr;
    status_next  = status;
    result_next  = result_address;
    usable_next  = usable_bytes;
    req.wen   = 1'b0;
    req.addr  = w[WordAw-1:0];
    req.wdata = PadWord;
    in_use    = 1'b0;
    pcand     = '0;
    gap       = '0;
    len       = '0;
    step      = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          status_next = StDone;
          result_next = '0;
          usable_next = '0;
          case (op)
            OpAlloc: begin
              wrapped_next = (alloc_offset >= OffW'(RingBytes));
              hh_next      = wrapped_next ? '0 : alloc_offset;
              state_next   = S_ACHECK;
            end
            OpFree, OpQuery: begin
              if (data_address == 32'd0) begin
                status_next = StNull;
                state_next  = S_OUT;
              end else if ((data_address - (base & BaseMask)) >= 32'(RingBytes)) begin
                status_next = StBacking;
                state_next  = S_OUT;
              end else begin
                w_next     = (WordAw+1)'((data_address - (base & BaseMask)) >> 2);
                state_next = S_FRD;
              end
            end
            default: state_next = S_OUT;
          endcase
        end
      end

      // compute data and end offsets, tail header if needed
      S_ACHECK: begin
        dd_next = (22'(hh) + 22'd4 + 22'(ralign) - 22'd1) & ~(22'(ralign) - 22'd1);
        pcand   = 23'(dd_next) + 23'(rsize);
        if (!wrapped && pcand > 23'(RingBytes)) begin
          req.wen      = 1'b1;
          req.addr     = hh[WordAw+1:2];
          req.wdata    = (32'(RingBytes) - 32'(hh)) | FreeMark;
          hh_next      = '0;
          dd_next      = 22'(ralign);
          pcand        = 23'(ralign) + 23'(rsize);
        end
        pp_next = pcand;
        state_next = S_AHDR;
      end

      S_AHDR: begin
        if (free_offset == alloc_offset) begin
          in_use = 1'b0;
        end else if (alloc_offset > free_offset) begin
          in_use = pp >= 23'(free_offset) && pp < 23'(alloc_offset);
        end else begin
          in_use = pp >= 23'(free_offset) || pp < 23'(alloc_offset);
        end
        if (pp > 23'(RingBytes) || in_use) begin
          status_next = StBacking;
          state_next  = S_OUT;
        end else begin
          req.wen           = 1'b1;
          req.addr          = hh[WordAw+1:2];
          req.wdata         = 32'(pp) - 32'(hh);
          alloc_offset_next = OffW'(pp);
          result_next       = (base & BaseMask) + 32'(dd);
          w_next            = (WordAw+1)'(hh[OffW-1:2]) + 1'b1;
          state_next        = S_APAD;
        end
      end

      S_APAD: begin
        if (22'(w) < (dd >> 2)) begin
          req.wen   = 1'b1;
          req.wdata = PadWord;
          w_next    = w + 1'b1;
        end else begin
          state_next = S_OUT;
        end
      end

      // back-walk: read word w-1
      S_FRD: begin
        if (w == '0) begin
          state_next = S_OUT;
        end else begin
          req.addr   = WordAw'(w - 1'b1);
          state_next = S_FCHK;
        end
      end

      S_FCHK: begin
        if (rdata == PadWord) begin
          w_next     = w - 1'b1;
          state_next = S_FRD;
        end else begin
          hdr_next   = rdata;
          w_next     = w - 1'b1;
          state_next = S_HDR;
        end
      end

      S_HDR: begin
        if (rop == OpQuery) begin
          len = hdr & SizeMask;
          gap = roff - {20'd0, w[WordAw-1:0], 2'b00};
          if (len > gap) begin
            usable_next = ((len - gap) > 32'(UsableMax)) ? UsableMax
                                                         : 21'(len - gap);
          end
          state_next = S_OUT;
        end else if ((hdr & FreeMark) != 32'd0) begin
          status_next = StDouble;
          state_next  = S_OUT;
        end else begin
          req.wen    = 1'b1;
          req.addr   = w[WordAw-1:0];
          req.wdata  = hdr | FreeMark;
          nstep_next = '0;
          state_next = S_FADV;
        end
      end

      // free-pointer advance: read header at free_offset
      S_FADV: begin
        if (nstep > WalkW'(RingWords) || free_offset == alloc_offset) begin
          state_next = S_OUT;
        end else begin
          req.addr   = free_offset[WordAw+1:2];
          state_next = S_FCHK2;
        end
      end

      S_FCHK2: begin
        step = rdata & SizeMask;
        if ((rdata & FreeMark) == 32'd0 || step == 32'd0 || step[1:0] != 2'd0 ||
            step > (32'(RingBytes) - 32'(free_offset)) ||
            free_offset >= OffW'(RingBytes)) begin
          state_next = S_OUT;
        end else begin
          free_offset_next = free_offset + OffW'(step);
          if (free_offset_next == OffW'(RingBytes)) free_offset_next = '0;
          nstep_next = nstep + 1'b1;
          state_next = S_FADV;
        end
      end

      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule
